@@ hdl/gcnms_pkg.sv @@
// ---------------------------------------------------------------------------
// gcnms_pkg: shared types and constants for the class-wise NMS filter
// Holds the box store geometry, the channel payloads and register indexes.
// ---------------------------------------------------------------------------
package gcnms_pkg;

   // Store and field geometry
   localparam int MAX_KEPT_DEPTH = 128;
   localparam int COORD_BITS     = 12;
   localparam int CLASS_BITS     = 10;
   localparam int CONF_BITS      = 16;
   localparam int ADDR_BITS      = $clog2(MAX_KEPT_DEPTH);
   localparam int COUNT_BITS     = ADDR_BITS + 1;
   localparam int LIMIT_BITS     = 8;

   // Derived arithmetic widths of the overlap test
   localparam int AREA_BITS  = 2 * COORD_BITS;
   localparam int UNION_BITS = AREA_BITS + 1;
   localparam int PROD_BITS  = UNION_BITS + CONF_BITS;

   // Configuration register port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONF_THRESHOLD    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OVERLAP_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_KEPT          = 2'd2;

   // Register reset values
   localparam logic [CONF_BITS-1:0]  CONF_THRESHOLD_RESET    = 16'd32768;
   localparam logic [CONF_BITS-1:0]  OVERLAP_THRESHOLD_RESET = 16'd26214;
   localparam logic [LIMIT_BITS-1:0] MAX_KEPT_RESET          = 8'd100;

   // One stored box with its class
   typedef struct packed {
      logic [CLASS_BITS-1:0] cls;
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] width;
      logic [COORD_BITS-1:0] height;
   } box_type;

   // Input transaction
   typedef struct packed {
      logic [CONF_BITS-1:0]  confidence;
      logic [CLASS_BITS-1:0] class_index;
      logic [COORD_BITS-1:0] box_left;
      logic [COORD_BITS-1:0] box_top;
      logic [COORD_BITS-1:0] box_width;
      logic [COORD_BITS-1:0] box_height;
      logic                  frame_last;
   } req_payload_type;

   // Result transaction
   typedef struct packed {
      logic                  kept;
      logic [ADDR_BITS-1:0]  kept_rank;
      logic [CONF_BITS-1:0]  out_confidence;
      logic [CLASS_BITS-1:0] out_class;
      logic [COORD_BITS-1:0] out_left;
      logic [COORD_BITS-1:0] out_top;
      logic [COORD_BITS-1:0] out_width;
      logic [COORD_BITS-1:0] out_height;
      logic                  frame_done;
   } rsp_payload_type;

endpackage

@@ hdl/gcnms_chan_if.sv @@
// ---------------------------------------------------------------------------
// gcnms_req_if / gcnms_rsp_if: valid-ready channels of the NMS filter
// A transaction moves at a rising edge with valid and ready both high.
// ---------------------------------------------------------------------------
interface gcnms_req_if;
   logic                      valid;
   logic                      ready;
   gcnms_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface gcnms_rsp_if;
   logic                      valid;
   logic                      ready;
   gcnms_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/gcnms_box_store.sv @@
// ---------------------------------------------------------------------------
// gcnms_box_store: single-port-write, single-port-read kept box memory
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module gcnms_box_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [gcnms_pkg::ADDR_BITS-1:0] wr_addr,
   input  gcnms_pkg::box_type             wr_data,
   input  logic                           rd_en,
   input  logic [gcnms_pkg::ADDR_BITS-1:0] rd_addr,
   output gcnms_pkg::box_type             rd_data
);

   gcnms_pkg::box_type mem [gcnms_pkg::MAX_KEPT_DEPTH];
   gcnms_pkg::box_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/gcnms_iou_unit.sv @@
// ---------------------------------------------------------------------------
// gcnms_iou_unit: pipelined same-class overlap test
// Flags a stored box whose IoU with the current box exceeds the threshold,
// tested as intersection * 2^16 > threshold * union. Five register stages.
// ---------------------------------------------------------------------------
module gcnms_iou_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  gcnms_pkg::box_type             stored_box,
   input  gcnms_pkg::box_type             item_box,
   input  logic [gcnms_pkg::CONF_BITS-1:0] overlap_threshold,
   output logic                           out_valid,
   output logic                           out_hit
);

   localparam int CB = gcnms_pkg::COORD_BITS;
   localparam int AB = gcnms_pkg::AREA_BITS;
   localparam int UB = gcnms_pkg::UNION_BITS;
   localparam int PB = gcnms_pkg::PROD_BITS;
   localparam int QB = gcnms_pkg::CONF_BITS;

   // Stage 1: intersection rectangle
   logic [CB-1:0] x1_s, y1_s;
   logic [CB:0]   r1_s, r2_s, b1_s, b2_s, x2_s, y2_s, ow_s, oh_s;
   logic          ov_s;

   logic          v1_ff, ov1_ff;
   logic [CB-1:0] ow1_ff, oh1_ff, w1_ff, h1_ff, w2_ff, h2_ff;
   logic          v2_ff, ov2_ff;
   logic [AB-1:0] inter2_ff, a1_2_ff, a2_2_ff;
   logic          v3_ff, ov3_ff;
   logic [AB-1:0] inter3_ff;
   logic [UB-1:0] uni3_ff;
   logic          v4_ff, ov4_ff;
   logic [AB-1:0] inter4_ff;
   logic [PB-1:0] prod4_ff;
   logic          v5_ff, hit5_ff;

   always_comb begin
      x1_s = (stored_box.left > item_box.left) ? stored_box.left : item_box.left;
      y1_s = (stored_box.top > item_box.top) ? stored_box.top : item_box.top;
      r1_s = {1'b0, stored_box.left} + {1'b0, stored_box.width};
      r2_s = {1'b0, item_box.left} + {1'b0, item_box.width};
      b1_s = {1'b0, stored_box.top} + {1'b0, stored_box.height};
      b2_s = {1'b0, item_box.top} + {1'b0, item_box.height};
      x2_s = (r1_s < r2_s) ? r1_s : r2_s;
      y2_s = (b1_s < b2_s) ? b1_s : b2_s;
      ow_s = x2_s - {1'b0, x1_s};
      oh_s = y2_s - {1'b0, y1_s};
      ov_s = (stored_box.cls == item_box.cls) &&
             (x2_s > {1'b0, x1_s}) && (y2_s > {1'b0, y1_s});
   end

   // Valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // Data pipeline: overlap sizes, areas, union, scaled union, compare
   always_ff @(posedge clock) begin
      ov1_ff    <= ov_s;
      ow1_ff    <= ow_s[CB-1:0];
      oh1_ff    <= oh_s[CB-1:0];
      w1_ff     <= stored_box.width;
      h1_ff     <= stored_box.height;
      w2_ff     <= item_box.width;
      h2_ff     <= item_box.height;

      ov2_ff    <= ov1_ff;
      inter2_ff <= ow1_ff * oh1_ff;
      a1_2_ff   <= w1_ff * h1_ff;
      a2_2_ff   <= w2_ff * h2_ff;

      ov3_ff    <= ov2_ff;
      inter3_ff <= inter2_ff;
      uni3_ff   <= {1'b0, a1_2_ff} + {1'b0, a2_2_ff} - {1'b0, inter2_ff};

      ov4_ff    <= ov3_ff;
      inter4_ff <= inter3_ff;
      prod4_ff  <= {{(PB-QB){1'b0}}, overlap_threshold} * {{(PB-UB){1'b0}}, uni3_ff};

      hit5_ff   <= ov4_ff &&
                   ({{(PB-AB-QB){1'b0}}, inter4_ff, {QB{1'b0}}} > prod4_ff);
   end

   assign out_valid = v5_ff;
   assign out_hit   = hit5_ff;

endmodule

@@ hdl/greedy_class_nms_filter.sv @@
// ---------------------------------------------------------------------------
// greedy_class_nms_filter: streaming greedy per-class non-maximum suppression
// Top level: configuration registers, scan sequencer and result register.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one detection per transaction; rsp_ch returns exactly one
//   result per detection, in order, with the keep flag and rank.
//   csr_* writes the confidence floor (0), overlap_threshold (1) and
//   max_kept (2); other indexes are ignored. Write only while idle.
// Timing:
//   A detection below the confidence threshold, or one arriving while the
//   frame has no kept boxes, goes from idle straight to the decision state,
//   where its result is registered. A passing detection scans the kept store
//   one entry per cycle through the pipelined IoU unit, which is then drained.
//   The single read port of the box store and the single IoU unit set that rate.
//   req_ch.ready is high only while the sequencer is idle.
// Reset and stall:
//   Reset restores the register defaults and empties the kept list. The last
//   detection of a frame empties it after its own result. When rsp_ch stalls,
//   the result is held; the next detection is accepted and processed, and
//   its result waits until the held one is taken.
// ---------------------------------------------------------------------------
module greedy_class_nms_filter (
   input  logic                                clock,
   input  logic                                reset,
   gcnms_req_if.sink                           req_ch,
   gcnms_rsp_if.source                         rsp_ch,
   input  logic                                csr_we,
   input  logic [gcnms_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [gcnms_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW = gcnms_pkg::ADDR_BITS;
   localparam int NW = gcnms_pkg::COUNT_BITS;
   localparam int LW = gcnms_pkg::LIMIT_BITS;
   localparam int QB = gcnms_pkg::CONF_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type                  state_ff, state_in;
   logic [QB-1:0]              conf_thr_ff, overlap_thr_ff;
   logic [LW-1:0]              max_kept_ff;
   logic [NW-1:0]              count_ff, count_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [2:0]                 inflight_ff, inflight_in;
   logic                       supp_ff, supp_in;
   logic                       rd_valid_ff;
   gcnms_pkg::req_payload_type item_ff;
   gcnms_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       accept, issue, retire, hit, out_free, commit, keep, pass;
   logic [LW-1:0]              limit;
   gcnms_pkg::box_type         item_box, rd_box;

   // Kept box store
   assign item_box = {item_ff.class_index, item_ff.box_left, item_ff.box_top,
                      item_ff.box_width, item_ff.box_height};

   gcnms_box_store u_store (
      .clock   (clock),
      .wr_en   (commit && keep),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (item_box),
      .rd_en   (issue),
      .rd_addr (idx_ff),
      .rd_data (rd_box)
   );

   // Shared overlap unit
   gcnms_iou_unit u_iou (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (rd_valid_ff),
      .stored_box        (rd_box),
      .item_box          (item_box),
      .overlap_threshold (overlap_thr_ff),
      .out_valid         (retire),
      .out_hit           (hit)
   );

   // Handshakes
   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign accept         = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;
   assign out_free       = !rsp_valid_ff || rsp_ch.ready;

   // Decision on the held detection
   assign limit  = (max_kept_ff > LW'(gcnms_pkg::MAX_KEPT_DEPTH)) ?
                   LW'(gcnms_pkg::MAX_KEPT_DEPTH) : max_kept_ff;
   assign pass   = (item_ff.confidence >= conf_thr_ff);
   assign keep   = pass && !supp_ff && (LW'(count_ff) < limit);
   assign commit = (state_ff == ST_DECIDE) && out_free;
   assign issue  = (state_ff == ST_SCAN);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      supp_in      = supp_ff || (retire && hit);
      count_in     = count_ff;
      inflight_in  = inflight_ff + {2'b00, issue} - {2'b00, retire};
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in  = '0;
               supp_in = 1'b0;
               if ((req_ch.payload.confidence >= conf_thr_ff) && (count_ff != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if ((NW'(idx_ff) + 1'b1) == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (inflight_ff == '0) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_in.kept           = keep;
               rsp_in.kept_rank      = keep ? count_ff[AW-1:0] : '0;
               rsp_in.out_confidence = item_ff.confidence;
               rsp_in.out_class      = item_ff.class_index;
               rsp_in.out_left       = item_ff.box_left;
               rsp_in.out_top        = item_ff.box_top;
               rsp_in.out_width      = item_ff.box_width;
               rsp_in.out_height     = item_ff.box_height;
               rsp_in.frame_done     = item_ff.frame_last;
               rsp_valid_in          = 1'b1;
               if (item_ff.frame_last) begin
                  count_in = '0;
               end else begin
                  count_in = count_ff + NW'(keep);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counters, configuration and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         inflight_ff    <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         supp_ff        <= 1'b0;
         idx_ff         <= '0;
         conf_thr_ff    <= gcnms_pkg::CONF_THRESHOLD_RESET;
         overlap_thr_ff <= gcnms_pkg::OVERLAP_THRESHOLD_RESET;
         max_kept_ff    <= gcnms_pkg::MAX_KEPT_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         inflight_ff  <= inflight_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
         supp_ff      <= supp_in;
         idx_ff       <= idx_in;
         if (csr_we) begin
            case (csr_index)
               gcnms_pkg::CSR_CONF_THRESHOLD:    conf_thr_ff    <= csr_data;
               gcnms_pkg::CSR_OVERLAP_THRESHOLD: overlap_thr_ff <= csr_data;
               gcnms_pkg::CSR_MAX_KEPT:          max_kept_ff    <= csr_data[LW-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers: capture the detection, hold the result
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         item_ff <= req_ch.payload;
      end
   end

endmodule
